// ===== hdl/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants of the cosine top-k search unit.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned ID_W      = 64;
  localparam int unsigned SCORE_W   = 32;
  localparam int unsigned TOPK_W    = 5;
  localparam int unsigned VLEN_W    = 11;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned ROOT_BITS = 31;
  localparam int unsigned SCALE_SH  = 60;

  localparam logic REG_TOP_K         = 1'b0;
  localparam logic REG_VECTOR_LENGTH = 1'b1;

  localparam logic [SCORE_W-1:0] SCORE_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_CHECK,
    ST_MUL,
    ST_PREP,
    ST_ROOT_A,
    ST_ROOT_B,
    ST_INSERT,
    ST_EMIT
  } cts_state_e;

  typedef struct packed {
    logic load;
    logic mac;
    logic mul_init;
    logic mul_step;
    logic prep;
    logic root_a;
    logic root_b;
    logic insert;
    logic pop;
  } cts_cmd_t;

  typedef struct packed {
    logic row_end;
    logic fin;
    logic qzero;
    logic rzero;
    logic mul_last;
    logic root_last;
    logic out_last;
  } cts_sts_t;

endpackage

// ===== hdl/cts_ctrl.sv =====
// ----------------------------------------------------------------------------
// cts_ctrl
// Sequencer for element load, accumulate, scoring, insertion and emit.
// ----------------------------------------------------------------------------
module cts_ctrl
  import cts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  cts_sts_t sts_i,
  output cts_cmd_t cmd_o
);

  cts_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd_o.mac = 1'b1;
        if (!sts_i.row_end) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.qzero || sts_i.rzero) begin
          state_d = ST_INSERT;
        end else begin
          cmd_o.mul_init = 1'b1;
          state_d        = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_ROOT_A;
      end
      ST_ROOT_A: begin
        cmd_o.root_a = 1'b1;
        state_d      = ST_ROOT_B;
      end
      ST_ROOT_B: begin
        cmd_o.root_b = 1'b1;
        state_d      = sts_i.root_last ? ST_INSERT : ST_ROOT_A;
      end
      ST_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = sts_i.fin ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.pop = 1'b1;
          if (sts_i.out_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");
  a_load_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_MAC)
    else $error("accepted word not accumulated");
  a_root_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.root_b && sts_i.root_last) |=> state_q == ST_INSERT)
    else $error("root search did not end in insertion");
  a_emit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pop && sts_i.out_last) |=> in_ready_o)
    else $error("no return to idle after last word");
`endif

endmodule

// ===== hdl/cts_datapath.sv =====
// ----------------------------------------------------------------------------
// cts_datapath
// Query store, accumulators, serial multipliers, root search and top-k list.
// ----------------------------------------------------------------------------
module cts_datapath
  import cts_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 1024,
  parameter int unsigned MAX_TOP    = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_addr_i,
  input  logic [CFG_W-1:0]          cfg_wdata_i,
  input  logic                      in_action_i,
  input  logic signed [VALUE_W-1:0] in_value_i,
  input  logic signed [ID_W-1:0]    in_id_i,
  input  logic                      in_final_i,
  input  cts_cmd_t                  cmd_i,
  output cts_sts_t                  sts_o,
  output logic [ID_W-1:0]           out_id_o,
  output logic [SCORE_W-1:0]        out_score_o,
  output logic                      out_status_o
);

  localparam int unsigned IW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned AW  = 32 + $clog2(MAX_LENGTH);
  localparam int unsigned PW  = 2 * AW;
  localparam int unsigned SW  = PW + 62;
  localparam int unsigned MCW = $clog2(AW);
  localparam int unsigned TW  = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
  localparam int unsigned CW  = $clog2(MAX_TOP + 1);

  // configuration
  logic [TOPK_W-1:0] top_k_q;
  logic [VLEN_W-1:0] vec_len_q;
  logic [16:0]       len_eff;
  logic [6:0]        k_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_k_q   <= TOPK_W'(1);
      vec_len_q <= VLEN_W'(128);
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_TOP_K) begin
        top_k_q <= cfg_wdata_i[TOPK_W-1:0];
      end else begin
        vec_len_q <= cfg_wdata_i[VLEN_W-1:0];
      end
    end
  end

  always_comb begin
    if (vec_len_q == '0) begin
      len_eff = 17'd1;
    end else if (17'(vec_len_q) > 17'(MAX_LENGTH)) begin
      len_eff = 17'(MAX_LENGTH);
    end else begin
      len_eff = 17'(vec_len_q);
    end
    if (top_k_q == '0) begin
      k_eff = 7'd1;
    end else if (7'(top_k_q) > 7'(MAX_TOP)) begin
      k_eff = 7'(MAX_TOP);
    end else begin
      k_eff = 7'(top_k_q);
    end
  end

  // element load
  logic [IW-1:0]              idx_q, idx_cur;
  logic                       is_row_q, last_q, fin_q, kind_row, idx_last;
  logic signed [VALUE_W-1:0]  v_q;
  logic signed [ID_W-1:0]     id_q;
  logic signed [AW-1:0]       dot_q;
  logic [AW-1:0]              qs_q, rs_q;
  logic [CW-1:0]              cnt_q;
  logic [VALUE_W-1:0]         mem [MAX_LENGTH];
  logic signed [VALUE_W-1:0]  rd_q;

  assign idx_cur  = (17'(idx_q) >= len_eff) ? '0 : idx_q;
  assign kind_row = (idx_cur == '0) ? in_action_i : is_row_q;
  assign idx_last = (17'(idx_cur) + 17'd1) == len_eff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !kind_row) begin
      mem[idx_cur] <= in_value_i;
    end
    rd_q <= mem[idx_cur];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q       <= in_value_i;
      id_q      <= in_id_i;
      fin_q     <= in_final_i;
      last_q    <= idx_last;
    end
  end

  logic signed [31:0] sq, prod;
  assign sq   = v_q * v_q;
  assign prod = rd_q * v_q;

  // serial multipliers and root search
  logic [PW-1:0]  pa_q, pacc_q, ma_q, macc_q;
  logic [AW-1:0]  pb_mul_q, mb_q, mag;
  logic [MCW-1:0] mcnt_q;
  logic [SW-1:0]  pb_q, d_q, t_q, w_q, tmp_q, w2_q, cand;
  logic [ROOT_BITS-1:0] s_q, bit_q;
  logic           neg_q;
  logic [SCORE_W-1:0] score;

  assign mag  = (dot_q < 0) ? AW'(-dot_q) : AW'(dot_q);
  assign cand = tmp_q + pb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_init) begin
      pa_q     <= PW'(qs_q);
      pb_mul_q <= rs_q;
      pacc_q   <= '0;
      ma_q     <= PW'(mag);
      mb_q     <= mag;
      macc_q   <= '0;
      mcnt_q   <= '0;
      neg_q    <= dot_q < 0;
    end else if (cmd_i.mul_step) begin
      if (pb_mul_q[0]) pacc_q <= pacc_q + pa_q;
      if (mb_q[0]) macc_q <= macc_q + ma_q;
      pa_q     <= pa_q << 1;
      ma_q     <= ma_q << 1;
      pb_mul_q <= pb_mul_q >> 1;
      mb_q     <= mb_q >> 1;
      mcnt_q   <= mcnt_q + MCW'(1);
    end
    if (cmd_i.prep) begin
      pb_q  <= SW'(pacc_q) << SCALE_SH;
      d_q   <= SW'(macc_q) << SCALE_SH;
      t_q   <= '0;
      w_q   <= '0;
      s_q   <= '0;
      bit_q <= {1'b1, {(ROOT_BITS-1){1'b0}}};
    end else if (cmd_i.root_a) begin
      tmp_q <= t_q + w_q;
      w2_q  <= w_q + (pb_q << 1);
    end else if (cmd_i.root_b) begin
      if (cand <= d_q) begin
        t_q <= cand;
        w_q <= w2_q >> 1;
        s_q <= s_q | bit_q;
      end else begin
        w_q <= w_q >> 1;
      end
      pb_q  <= pb_q >> 2;
      bit_q <= bit_q >> 1;
    end
  end

  assign score = rs_q == '0 ? SCORE_MIN
               : (neg_q ? -{1'b0, s_q} : {1'b0, s_q});

  // sorted list
  logic signed [ID_W-1:0]    ids_q [MAX_TOP];
  logic signed [SCORE_W-1:0] sc_q  [MAX_TOP];
  logic signed [ID_W-1:0]    prv_id [MAX_TOP];
  logic signed [SCORE_W-1:0] prv_sc [MAX_TOP];
  logic [MAX_TOP-1:0]        keep, prv_keep, kmask;
  logic [CW-1:0]             cnt_e, cnt_ins;
  logic                      ins_ok;
  logic [TW-1:0]             oidx_q;

  assign cnt_e = (7'(cnt_q) > k_eff) ? CW'(k_eff) : cnt_q;

  for (genvar gi = 0; gi < MAX_TOP; gi++) begin : g_list
    if (gi == 0) begin : g_head
      assign prv_id[gi]   = id_q;
      assign prv_sc[gi]   = score;
      assign prv_keep[gi] = 1'b1;
    end else begin : g_body
      assign prv_id[gi]   = ids_q[gi-1];
      assign prv_sc[gi]   = sc_q[gi-1];
      assign prv_keep[gi] = keep[gi-1];
    end
    assign kmask[gi] = 7'(gi) < k_eff;
    assign keep[gi]  = (7'(gi) < 7'(cnt_e)) &&
                       !(($signed(score) > sc_q[gi]) ||
                         ($signed(score) == sc_q[gi] && id_q < ids_q[gi]));

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert && !sts_o.qzero && kmask[gi] && !keep[gi]) begin
        if (prv_keep[gi]) begin
          ids_q[gi] <= id_q;
          sc_q[gi]  <= score;
        end else begin
          ids_q[gi] <= prv_id[gi];
          sc_q[gi]  <= prv_sc[gi];
        end
      end
    end
  end

  assign ins_ok  = |(~keep & kmask);
  assign cnt_ins = (7'(cnt_e) + 7'd1 > k_eff) ? CW'(k_eff) : cnt_e + CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      is_row_q <= 1'b0;
      qs_q     <= '0;
      rs_q     <= '0;
      dot_q    <= '0;
      cnt_q    <= '0;
      oidx_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= idx_last ? '0 : idx_cur + IW'(1);
        if (idx_cur == '0) begin
          is_row_q <= in_action_i;
          if (in_action_i) begin
            dot_q <= '0;
            rs_q  <= '0;
          end else begin
            qs_q  <= '0;
            cnt_q <= '0;
          end
        end
      end
      if (cmd_i.mac) begin
        if (!is_row_q) begin
          qs_q <= qs_q + AW'($unsigned(sq));
        end else begin
          dot_q <= dot_q + AW'(prod);
          rs_q  <= rs_q + AW'($unsigned(sq));
        end
      end
      if (cmd_i.insert) begin
        oidx_q <= '0;
        cnt_q  <= (!sts_o.qzero && ins_ok) ? cnt_ins : cnt_e;
      end
      if (cmd_i.pop) begin
        oidx_q <= oidx_q + TW'(1);
        if (sts_o.out_last) cnt_q <= '0;
      end
    end
  end

  assign sts_o.row_end   = is_row_q & last_q;
  assign sts_o.fin       = fin_q;
  assign sts_o.qzero     = qs_q == '0;
  assign sts_o.rzero     = rs_q == '0;
  assign sts_o.mul_last  = mcnt_q == MCW'(AW - 1);
  assign sts_o.root_last = bit_q[0];
  assign sts_o.out_last  = (qs_q == '0) || ((7'(oidx_q) + 7'd1) == 7'(cnt_q));

  assign out_status_o = qs_q == '0;
  assign out_id_o     = out_status_o ? '0 : ids_q[oidx_q];
  assign out_score_o  = out_status_o ? '0 : sc_q[oidx_q];

endmodule

// ===== hdl/cosine_top_k_search_unit.sv =====
// ----------------------------------------------------------------------------
// cosine_top_k_search_unit
// Exact cosine similarity scoring of streamed rows with a sorted top-k list.
// ----------------------------------------------------------------------------
// channel  | direction | payload
// s_axis   | in        | tdata {row_id, element_value}, tuser action, tlast final_row
// m_axis   | out       | tdata {similarity, result_id}, tuser status, tlast last
// cfg      | in        | index 0 top_k, index 1 vector_length
//
// each element is loaded in ST_IDLE, where the query store is read, then accumulated in ST_MAC
// a row's last element then goes through norm check, serial multipliers, prep,
// 31 root steps (ST_ROOT_A, ST_ROOT_B) and insert; a zero norm goes from the check straight to insert
// results leave one word per cycle while m_axis_tready_i is high
// reset is asynchronous; the query store holds no reset value
// no input is taken while results are being sent
// ----------------------------------------------------------------------------
module cosine_top_k_search_unit
  import cts_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 1024,
  parameter int unsigned MAX_TOP    = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_addr_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [79:0]      s_axis_tdata_i,   // element_value, row_id
  input  logic             s_axis_tuser_i,   // action
  input  logic             s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [95:0]      m_axis_tdata_o,   // result_id, similarity
  output logic             m_axis_tuser_o,   // status
  output logic             m_axis_tlast_o
);

  cts_cmd_t cmd;
  cts_sts_t sts;
  logic [ID_W-1:0]    out_id;
  logic [SCORE_W-1:0] out_score;

  cts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cts_datapath #(
    .MAX_LENGTH (MAX_LENGTH),
    .MAX_TOP    (MAX_TOP)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_action_i  (s_axis_tuser_i),
    .in_value_i   (s_axis_tdata_i[15:0]),
    .in_id_i      (s_axis_tdata_i[79:16]),
    .in_final_i   (s_axis_tlast_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_id_o     (out_id),
    .out_score_o  (out_score),
    .out_status_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {out_score, out_id};
  assign m_axis_tlast_o = sts.out_last;

endmodule

// ===== tb/sv/cts_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cts_checker
// Watches the config port and both stream channels of the search unit. Keeps
// its own copy of the query, the row sums and the sorted top-k list, works
// out the id/score words each final row should produce and compares
// every outgoing word field by field against the oldest one waiting.
// ----------------------------------------------------------------------------
module cts_checker
  import cts_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 1024,
  parameter int unsigned MAX_TOP    = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_addr_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid_i,
  input  logic             s_axis_tready_i,
  input  logic [79:0]      s_axis_tdata_i,   // element_value, row_id
  input  logic             s_axis_tuser_i,   // action
  input  logic             s_axis_tlast_i,
  input  logic             m_axis_tvalid_i,
  input  logic             m_axis_tready_i,
  input  logic [95:0]      m_axis_tdata_i,   // result_id, similarity
  input  logic             m_axis_tuser_i,   // status
  input  logic             m_axis_tlast_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct {
    logic signed [ID_W-1:0]    id;
    logic signed [SCORE_W-1:0] score;
    logic                      status;
    logic                      last;
  } hit_t;

  hit_t                      hits_due[$];
  logic [TOPK_W-1:0]         top_k_reg;
  logic [VLEN_W-1:0]         vlen_reg;
  logic [VALUE_W-1:0]        query_mem[MAX_LENGTH];
  int unsigned               elem_idx;
  logic [63:0]               q_energy;
  longint                    dot_sum;
  logic [63:0]               r_energy;
  logic signed [ID_W-1:0]    list_ids[MAX_TOP];
  logic signed [SCORE_W-1:0] list_scores[MAX_TOP];
  int unsigned               list_len;
  logic                      in_row;
  int                        fails;

  assign fail_count_o = fails;
  assign pending_o    = hits_due.size();

  function automatic logic signed [SCORE_W-1:0] cosine_q30(logic [63:0] qs, logic [63:0] rs,
                                                          longint dp);
    logic [191:0] norm_prod, num, trial, lhs;
    logic [63:0]  mag;
    logic [30:0]  root;
    mag       = dp < 0 ? 64'(-dp) : 64'(dp);
    norm_prod = 192'(qs) * 192'(rs);
    num       = (192'(mag) * 192'(mag)) << 60;
    root      = '0;
    for (int b = 30; b >= 0; b--) begin
      trial = 192'(root) | (192'(1) << b);
      lhs   = trial * trial * norm_prod;
      if (lhs <= num) root = trial[30:0];
    end
    return dp < 0 ? -$signed({1'b0, root}) : $signed({1'b0, root});
  endfunction

  task automatic insert_hit(logic signed [ID_W-1:0] id, logic signed [SCORE_W-1:0] sc,
                            int unsigned k);
    int unsigned pos, stop;
    pos = 0;
    while (pos < list_len && (list_scores[pos] > sc ||
           (list_scores[pos] == sc && !(id < list_ids[pos]))))
      pos++;
    if (pos < k) begin
      stop = list_len < k ? list_len : k - 1;
      for (int unsigned i = stop; i > pos; i--) begin
        list_ids[i]    = list_ids[i-1];
        list_scores[i] = list_scores[i-1];
      end
      list_ids[pos]    = id;
      list_scores[pos] = sc;
      list_len         = stop + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic                      act, fin, at_end;
    logic signed [VALUE_W-1:0] val, qv;
    logic signed [ID_W-1:0]    rid;
    int unsigned               len, k;
    hit_t                      h, got;
    if (!rst_ni) begin
      top_k_reg = 1;
      vlen_reg  = 128;
      elem_idx  = 0;
      q_energy  = '0;
      dot_sum   = 0;
      r_energy  = '0;
      list_len  = 0;
      in_row    = 1'b0;
      fails     = 0;
      hits_due.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_TOP_K) top_k_reg = cfg_wdata_i[TOPK_W-1:0];
        else vlen_reg = cfg_wdata_i[VLEN_W-1:0];
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        act = s_axis_tuser_i;
        val = s_axis_tdata_i[15:0];
        rid = s_axis_tdata_i[79:16];
        fin = s_axis_tlast_i;
        len = vlen_reg == 0 ? 1 : (vlen_reg > MAX_LENGTH ? MAX_LENGTH : vlen_reg);
        if (elem_idx >= len) elem_idx = 0;
        if (elem_idx == 0) begin
          in_row = act;
          if (act) begin
            dot_sum  = 0;
            r_energy = '0;
          end else begin
            q_energy = '0;
            list_len = 0;
          end
        end
        if (!in_row) begin
          query_mem[elem_idx] = val;
          q_energy += 64'(longint'(val) * longint'(val));
        end else begin
          qv = query_mem[elem_idx];
          dot_sum  += longint'(qv) * longint'(val);
          r_energy += 64'(longint'(val) * longint'(val));
        end
        at_end   = elem_idx + 1 == len;
        elem_idx = at_end ? 0 : elem_idx + 1;
        if (in_row && at_end) begin
          k = top_k_reg == 0 ? 1 : (top_k_reg > MAX_TOP ? MAX_TOP : top_k_reg);
          if (list_len > k) list_len = k;
          if (q_energy != 0)
            insert_hit(rid, r_energy == 0 ? $signed(SCORE_MIN) :
                       cosine_q30(q_energy, r_energy, dot_sum), k);
          if (fin) begin
            if (q_energy == 0) begin
              h = '{id: 0, score: 0, status: 1'b1, last: 1'b1};
              hits_due.insert(hits_due.size(), h);
            end else begin
              for (int unsigned i = 0; i < list_len; i++) begin
                h = '{id: list_ids[i], score: list_scores[i], status: 1'b0,
                      last: i + 1 == list_len};
                hits_due.insert(hits_due.size(), h);
              end
            end
            list_len = 0;
          end
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = '{id: m_axis_tdata_i[63:0], score: m_axis_tdata_i[95:64],
                status: m_axis_tuser_i, last: m_axis_tlast_i};
        if (hits_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected word: id %0d score %0d status %b last %b",
                     got.id, got.score, got.status, got.last);
        end else begin
          h = hits_due.pop_front();
          if (got.id !== h.id || got.score !== h.score || got.status !== h.status ||
              got.last !== h.last) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp id %0d sc %0d st %b l %b, got id %0d sc %0d st %b l %b",
                       h.id, h.score, h.status, h.last,
                       got.id, got.score, got.status, got.last);
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the cosine top-k search unit. Loads queries and
// streams runs of rows under several top_k / vector_length settings, first
// directed cases (extreme values, zero-norm rows, zero query, ties, a query
// reload mid-run) then random runs, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module testbench;
  import cts_pkg::*;

  localparam int unsigned SETTLE = 400;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic             cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;
  logic             s_valid;
  logic             s_ready;
  logic [79:0]      s_data;    // element_value, row_id
  logic             s_user;    // action
  logic             s_last;    // final_row
  logic             m_valid;
  logic             m_ready;
  logic [95:0]      m_data;    // result_id, similarity
  logic             m_user;    // status
  logic             m_last;
  int               fail_count;
  int               pending;

  logic [VALUE_W-1:0] query_copy[1024];
  logic [VALUE_W-1:0] row_buf[1024];
  int unsigned        burst_left;
  int unsigned        random_items;
  int unsigned        cur_len;

  cosine_top_k_search_unit u_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .s_axis_tuser_i(s_user), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  cts_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready), .s_axis_tdata_i(s_data),
    .s_axis_tuser_i(s_user), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_i(m_data),
    .m_axis_tuser_i(m_user), .m_axis_tlast_i(m_last),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("cosine_top_k_search_unit regression: fail");
    $finish;
  end

  // output stall pattern, with one long hold-off while input keeps coming
  initial begin
    int unsigned mode, span;
    m_ready = 1'b0;
    @(posedge rst_ni);
    repeat (1500) begin
      @(posedge clk_i);
      m_ready <= ($urandom_range(0, 3) != 0);
    end
    @(posedge clk_i);
    m_ready <= 1'b0;
    repeat (3000) @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk_i);
        m_ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 2 * mode) != 0);
      end
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value(int unsigned style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 1023)) - 512);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return '0;
    endcase
  endfunction

  task automatic send_word(logic act, logic [VALUE_W-1:0] val, logic [ID_W-1:0] id,
                           logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= {id, val};
    s_user  <= act;
    s_last  <= fin;
    do @(posedge clk_i); while (!s_ready);
  endtask

  // action and final_row only count on the first / last element
  task automatic send_query(int unsigned style);
    for (int unsigned i = 0; i < cur_len; i++) begin
      query_copy[i] = pick_value(style);
      send_word(i == 0 ? 1'b0 : 1'($urandom), query_copy[i],
                {$urandom, $urandom}, 1'($urandom));
    end
  endtask

  task automatic send_row(logic [ID_W-1:0] id, logic fin);
    for (int unsigned i = 0; i < cur_len; i++)
      send_word(i == 0 ? 1'b1 : 1'($urandom), row_buf[i],
                (i + 1 == cur_len) ? id : {$urandom, $urandom},
                (i + 1 == cur_len) ? fin : 1'($urandom));
  endtask

  // style 4 copies the query, 5 negates it
  task automatic fill_row(int unsigned style);
    for (int unsigned i = 0; i < cur_len; i++)
      case (style)
        4: row_buf[i] = query_copy[i];
        5: row_buf[i] = -query_copy[i];
        default: row_buf[i] = pick_value(style);
      endcase
  endtask

  task automatic settle();
    @(posedge clk_i);
    s_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [CFG_W-1:0] k, logic [CFG_W-1:0] len);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_TOP_K;
    cfg_wdata <= k;
    @(posedge clk_i);
    cfg_addr  <= REG_VECTOR_LENGTH;
    cfg_wdata <= len;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_len = len == 0 ? 1 : (len > 1024 ? 1024 : len);
  endtask

  task automatic random_run(int unsigned rows);
    for (int unsigned r = 0; r < rows; r++) begin
      fill_row($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 5));
      send_row({$urandom, $urandom}, r + 1 == rows);
      random_items += cur_len;
    end
  endtask

  initial begin
    logic [CFG_W-1:0] k_list[8]   = '{16, 1, 0, 20, 7, 3, 16, 5};
    logic [CFG_W-1:0] len_list[8] = '{1, 6, 3, 5, 0, 12, 4, 2};
    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = REG_TOP_K;
    cfg_wdata  = '0;
    s_valid    = 1'b0;
    s_data     = '0;
    s_user     = 1'b0;
    s_last     = 1'b0;
    burst_left = 0;
    random_items = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, zero-norm row, exact match, opposite, ties, id extremes
    set_regs(4, 2);
    send_query(2);
    fill_row(3);
    send_row(64'sd9, 1'b0);
    fill_row(4);
    send_row(64'h8000_0000_0000_0000, 1'b0);
    fill_row(5);
    send_row(64'h7fff_ffff_ffff_ffff, 1'b0);
    fill_row(1);
    send_row(64'sd5, 1'b0);
    send_row(-64'sd3, 1'b0);
    send_row(64'sd5, 1'b1);
    settle();
    // zero query gives one error word; then a query reload mid-run
    send_query(3);
    fill_row(2);
    send_row(64'sd1, 1'b0);
    send_row(64'sd2, 1'b1);
    send_query(2);
    fill_row(0);
    send_row(64'sd11, 1'b0);
    send_query(1);
    fill_row(4);
    send_row(64'sd12, 1'b1);
    settle();

    foreach (k_list[p]) begin
      set_regs(k_list[p], len_list[p]);
      send_query($urandom_range(0, 2));
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 7) == 0) send_query($urandom_range(0, 7) == 0 ? 3 : 0);
        random_run($urandom_range(1, 3));
      end
      settle();
    end
    while (random_items < 140) begin
      send_query($urandom_range(0, 9) == 0 ? 3 : 1);
      random_run($urandom_range(1, 6));
    end
    settle();

    if (fail_count == 0)
      $display("cosine_top_k_search_unit regression: pass");
    else
      $display("cosine_top_k_search_unit regression: fail");
    $finish;
  end

endmodule
